[sv/sffm_pkg.sv]
// Package for the sticky fault flag monitor.
// Holds the action codes, fault bit positions and the beat structs shared by all modules.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sffm_pkg;

    localparam int unsigned FLAG_W = 6;
    localparam int unsigned CNT_W  = 4;
    localparam int unsigned MS_W   = 32;

    // Fault bit positions
    localparam int unsigned BIT_IMU_LOST     = 0;
    localparam int unsigned BIT_I2S_LEFT     = 1;
    localparam int unsigned BIT_I2S_RIGHT    = 2;
    localparam int unsigned BIT_AUDIO_CLIP   = 3;
    localparam int unsigned BIT_BUTTON_STUCK = 4;
    localparam int unsigned BIT_SD_LOG       = 5;

    localparam logic [FLAG_W-1:0] FLAG_SD_LOG = FLAG_W'(1) << BIT_SD_LOG;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_IMU_FAIL_LIMIT   = 2'd0,
        REG_BUTTON_STUCK_MS  = 2'd1,
        REG_REPORT_PERIOD_MS = 2'd2,
        REG_SD_ONLY_PERIOD   = 2'd3
    } reg_index_t;

    localparam logic [CNT_W-1:0] IMU_FAIL_LIMIT_RST  = 4'd5;
    localparam logic [MS_W-1:0]  BUTTON_STUCK_RST    = 32'd10000;
    localparam logic [MS_W-1:0]  REPORT_PERIOD_RST   = 32'd1000;
    localparam logic [MS_W-1:0]  SD_ONLY_PERIOD_RST  = 32'd10000;

    typedef enum logic [2:0] {
        ACT_IMU_READ = 3'd0,
        ACT_I2S_ERR  = 3'd1,
        ACT_BUTTON   = 3'd2,
        ACT_SET_MASK = 3'd3,
        ACT_CLEAR    = 3'd4,
        ACT_TICK     = 3'd5
    } action_t;

    // One input beat
    typedef struct packed {
        logic [2:0]        action;
        logic              read_ok;
        logic              i2s_left_err;
        logic              i2s_right_err;
        logic [MS_W-1:0]   held_ms;
        logic [FLAG_W-1:0] set_mask;
        logic [MS_W-1:0]   now_ms;
    } event_t;

    // Configuration register set
    typedef struct packed {
        logic [CNT_W-1:0] imu_fail_limit;
        logic [MS_W-1:0]  button_stuck_ms;
        logic [MS_W-1:0]  report_period_ms;
        logic [MS_W-1:0]  sd_only_period_ms;
    } cfg_t;

    // One result beat
    typedef struct packed {
        logic [FLAG_W-1:0] fault_flags;
        logic              report_now;
    } result_t;

endpackage

`default_nettype wire

[sv/sffm_in_reg.sv]
// Input register stage of the sticky fault flag monitor.
// Captures one event beat and holds it until the core stage can advance.
// Depends on sffm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sffm_in_reg (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_stall,
    input  wire sffm_pkg::event_t in_event,
    input  wire logic            advance,
    output logic                 ev_valid,
    output sffm_pkg::event_t     ev
);
    import sffm_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    event_t event_reg;
    logic   accept;

    assign in_stall = valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            event_reg <= in_event;
        end
    end

    assign ev_valid = valid_reg;
    assign ev       = event_reg;

endmodule

`default_nettype wire

[sv/sffm_core.sv]
// Fault state and decision logic of the sticky fault flag monitor.
// Holds sticky flags, report history and imu failure count; computes one result per beat.
// Depends on sffm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sffm_core (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             fire,
    input  wire sffm_pkg::event_t ev,
    input  wire sffm_pkg::cfg_t   cfg,
    output sffm_pkg::result_t     result
);
    import sffm_pkg::*;

    logic [FLAG_W-1:0] flags_reg;
    logic [FLAG_W-1:0] flags_next;
    logic [FLAG_W-1:0] last_rep_reg;
    logic [FLAG_W-1:0] last_rep_next;
    logic [MS_W-1:0]   last_time_reg;
    logic [MS_W-1:0]   last_time_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              report;
    logic [MS_W-1:0]   period;
    logic [MS_W-1:0]   elapsed;

    always_comb
    begin
        flags_next     = flags_reg;
        last_rep_next  = last_rep_reg;
        last_time_next = last_time_reg;
        cnt_next       = cnt_reg;
        report         = 1'b0;
        period  = ((flags_reg & ~FLAG_SD_LOG) == '0) ? cfg.sd_only_period_ms
                                                     : cfg.report_period_ms;
        elapsed = ev.now_ms - last_time_reg;

        unique case (action_t'(ev.action))
            ACT_IMU_READ:
            begin
                if (ev.read_ok)
                begin
                    cnt_next = '0;
                end
                else
                begin
                    if (cnt_reg < cfg.imu_fail_limit)
                    begin
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                    if (cnt_next >= cfg.imu_fail_limit)
                    begin
                        flags_next[BIT_IMU_LOST] = 1'b1;
                    end
                end
            end
            ACT_I2S_ERR:
            begin
                flags_next[BIT_I2S_LEFT]  = flags_reg[BIT_I2S_LEFT]  | ev.i2s_left_err;
                flags_next[BIT_I2S_RIGHT] = flags_reg[BIT_I2S_RIGHT] | ev.i2s_right_err;
            end
            ACT_BUTTON:
            begin
                if (ev.held_ms >= cfg.button_stuck_ms)
                begin
                    flags_next[BIT_BUTTON_STUCK] = 1'b1;
                end
            end
            ACT_SET_MASK:
            begin
                flags_next = flags_reg | ev.set_mask;
            end
            ACT_CLEAR:
            begin
                flags_next     = '0;
                last_rep_next  = '0;
                last_time_next = '0;
                cnt_next       = '0;
            end
            ACT_TICK:
            begin
                if (flags_reg == '0)
                begin
                    last_rep_next = '0;
                end
                else if (!(flags_reg == last_rep_reg && elapsed < period))
                begin
                    last_rep_next  = flags_reg;
                    last_time_next = ev.now_ms;
                    report         = 1'b1;
                end
            end
            default:
            begin
                // unused codes leave the state alone
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg     <= '0;
            last_rep_reg  <= '0;
            last_time_reg <= '0;
            cnt_reg       <= '0;
        end
        else if (fire)
        begin
            flags_reg     <= flags_next;
            last_rep_reg  <= last_rep_next;
            last_time_reg <= last_time_next;
            cnt_reg       <= cnt_next;
        end
    end

    assign result.fault_flags = flags_next;
    assign result.report_now  = report;

`ifndef SYNTHESIS
    a_clear_wipes: assert property (@(posedge clk) disable iff (!rst_n)
        fire && ev.action == ACT_CLEAR |=> flags_reg == '0 && cnt_reg == '0
            && last_rep_reg == '0 && last_time_reg == '0)
        else $error("clear did not wipe fault state");

    a_report_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        fire && report |-> ev.action == ACT_TICK && flags_reg != '0)
        else $error("report outside a tick with flags set");

    a_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        fire && ev.action != ACT_CLEAR |=>
            (flags_reg & $past(flags_reg)) == $past(flags_reg))
        else $error("sticky flag dropped without clear");

    a_report_records: assert property (@(posedge clk) disable iff (!rst_n)
        fire && report |=> last_time_reg == $past(ev.now_ms)
            && last_rep_reg == $past(flags_reg))
        else $error("report not recorded");
`endif

endmodule

`default_nettype wire

[sv/sticky_fault_flag_monitor.sv]
// Top level of the sticky fault flag monitor.
// Holds the configuration registers, the result register and the handshake.
// Depends on sffm_pkg, sffm_in_reg and sffm_core.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one event beat: action plus
//   its operand fields. Output channel (out_valid / out_stall) returns exactly
//   one beat per event: the sticky flags after the event and report_now.
//   Configuration: cfg_we writes cfg_data into the register picked by
//   cfg_index (0 imu fail limit, 1 button stuck ms, 2 report period ms,
//   3 sd-only period ms). Write only while no event is in flight.
// Pipeline and throughput:
//   An accepted beat goes from the input register to the result register.
//   One beat per cycle is sustained while out_stall is low: the input
//   register feeds a single pass of compare and update logic that writes
//   the state and the result register in the same edge.
// Reset:
//   rst_n clears flags, report history, time stamp and failure count, empties
//   both pipeline registers and loads the default configuration.
// Stall:
//   While out_stall holds a waiting result, the input register holds its beat
//   and in_stall is high; an empty input register still takes one more event.
`timescale 1ns / 1ps
`default_nettype none

module sticky_fault_flag_monitor (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // event channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  action,
    input  wire logic        read_ok,
    input  wire logic        i2s_left_err,
    input  wire logic        i2s_right_err,
    input  wire logic [31:0] held_ms,
    input  wire logic [5:0]  set_mask,
    input  wire logic [31:0] now_ms,
    // result channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [5:0]       fault_flags,
    output logic             report_now,
    // configuration port
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    import sffm_pkg::*;

    event_t  in_event;
    event_t  ev;
    logic    ev_valid;
    logic    advance;
    logic    fire;
    cfg_t    cfg_reg;
    result_t result;
    result_t result_reg;
    logic    out_valid_reg;
    logic    out_valid_next;

    // Bundle the event fields into one beat
    assign in_event.action        = action;
    assign in_event.read_ok       = read_ok;
    assign in_event.i2s_left_err  = i2s_left_err;
    assign in_event.i2s_right_err = i2s_right_err;
    assign in_event.held_ms       = held_ms;
    assign in_event.set_mask      = set_mask;
    assign in_event.now_ms        = now_ms;

    // Advance the core stage whenever the result register is empty or drains
    assign advance = !out_valid_reg || !out_stall;
    assign fire    = ev_valid && advance;

    sffm_in_reg u_in_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_event (in_event),
        .advance  (advance),
        .ev_valid (ev_valid),
        .ev       (ev)
    );

    sffm_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .ev     (ev),
        .cfg    (cfg_reg),
        .result (result)
    );

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.imu_fail_limit    <= IMU_FAIL_LIMIT_RST;
            cfg_reg.button_stuck_ms   <= BUTTON_STUCK_RST;
            cfg_reg.report_period_ms  <= REPORT_PERIOD_RST;
            cfg_reg.sd_only_period_ms <= SD_ONLY_PERIOD_RST;
        end
        else if (cfg_we)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_IMU_FAIL_LIMIT:   cfg_reg.imu_fail_limit    <= cfg_data[CNT_W-1:0];
                REG_BUTTON_STUCK_MS:  cfg_reg.button_stuck_ms   <= cfg_data;
                REG_REPORT_PERIOD_MS: cfg_reg.report_period_ms  <= cfg_data;
                REG_SD_ONLY_PERIOD:   cfg_reg.sd_only_period_ms <= cfg_data;
                default:              cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Result register: load on fire, drop once the beat is taken
    always_comb
    begin
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            result_reg <= result;
        end
    end

    assign out_valid   = out_valid_reg;
    assign fault_flags = result_reg.fault_flags;
    assign report_now  = result_reg.report_now;

endmodule

`default_nettype wire
